// ===== rtl/sbt_pkg.sv =====
package sbt_pkg;

    localparam int EPOCH_W = 32;
    localparam int CFG_W   = 48;
    localparam int CODE_W  = 3;
    localparam int SLOT_W  = 6;
    localparam int REM_W   = 11;
    localparam int QUOT_W  = 22;
    localparam int DIV_W   = 9;
    localparam int ONLEN_W = 5;
    localparam int RECIP_W = 15;
    localparam int FRAC_W  = 20;
    localparam int MINQ_W  = 5;
    localparam int INDEX_W = 2;

    localparam logic [REM_W-1:0] SLOT_SECONDS = 11'd1800;

    localparam logic [29:0] RECIP_225       = 30'd610839794;
    localparam int          RECIP_225_SHIFT = 37;

    localparam logic [RECIP_W-1:0] RECIP_300 = 15'd3496;
    localparam logic [RECIP_W-1:0] RECIP_120 = 15'd8739;
    localparam logic [RECIP_W-1:0] RECIP_60  = 15'd17477;

    localparam logic [CODE_W-1:0] CODE_OFF    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_SHORT  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_MEDIUM = 3'd2;
    localparam logic [CODE_W-1:0] CODE_LONG   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_ALWAYS = 3'd4;

    localparam logic [INDEX_W-1:0] REG_FIRST  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_MIDDLE = 2'd1;
    localparam logic [INDEX_W-1:0] REG_LAST   = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [EPOCH_W-1:0]   now;
        logic [REM_W-1:0]     rem;
        logic [SLOT_W-1:0]    slot;
    } split_t;

    function automatic logic [1:0] mod3_18(input logic [17:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = 5'd0;
        for (int i = 0; i < 9; i++)
        begin
            s1 = s1 + 5'(v[2*i +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        if (s3 >= 3'd3)
        begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

endpackage

// ===== rtl/sbt_slot_split.sv =====
module sbt_slot_split (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [sbt_pkg::EPOCH_W-1:0]  in_epoch,
    output sbt_pkg::split_t              split
);

    logic                         v0_reg;
    logic [sbt_pkg::EPOCH_W-1:0]  now0_reg;
    logic                         v1_reg;
    logic [sbt_pkg::EPOCH_W-1:0]  now1_reg;
    logic [sbt_pkg::QUOT_W-1:0]   q1_reg;
    logic [sbt_pkg::QUOT_W-1:0]   q1_next;
    logic [58:0]                  recip_prod;
    logic [sbt_pkg::EPOCH_W-1:0]  slot_base;
    logic [sbt_pkg::EPOCH_W-1:0]  rem_full;
    logic                         split_valid_reg;
    logic [sbt_pkg::EPOCH_W-1:0]  split_now_reg;
    logic [sbt_pkg::REM_W-1:0]    split_rem_reg;
    logic [sbt_pkg::SLOT_W-1:0]   split_slot_reg;
    sbt_pkg::split_t              split_next;

    // quotient by 1800: shift out the factor 8, then multiply by the reciprocal of 225
    assign recip_prod = 59'(now0_reg[31:3]) * 59'(sbt_pkg::RECIP_225);
    assign q1_next    = recip_prod[sbt_pkg::RECIP_225_SHIFT +: sbt_pkg::QUOT_W];

    assign slot_base  = 32'(q1_reg) * 32'(sbt_pkg::SLOT_SECONDS);
    assign rem_full   = now1_reg - slot_base;

    always_comb
    begin
        split_next.valid = v1_reg;
        split_next.now   = now1_reg;
        split_next.rem   = rem_full[sbt_pkg::REM_W-1:0];
        split_next.slot  = {sbt_pkg::mod3_18(q1_reg[21:4]), q1_reg[3:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            split_valid_reg <= 1'b0;
        end
        else
        begin
            v0_reg          <= in_valid;
            v1_reg          <= v0_reg;
            split_valid_reg <= split_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        now0_reg       <= in_epoch;
        now1_reg       <= now0_reg;
        q1_reg         <= q1_next;
        split_now_reg  <= split_next.now;
        split_rem_reg  <= split_next.rem;
        split_slot_reg <= split_next.slot;
    end

    assign split = {split_valid_reg, split_now_reg, split_rem_reg, split_slot_reg};

endmodule

// ===== rtl/slot_schedule_burst_timer.sv =====
// Pump burst scheduler.
// Command channel: drive current_epoch with start high; busy is always low,
// so a new epoch second is taken at every clock edge with start high.
// Result channel: done pulses for one cycle with pump_on and next_wake.
// Each item is registered on entry and then runs through a chain of
// multipliers, with one item per cycle sustained: quotient by 1800 and slot
// remainder, then quotient by the burst period and burst remainder, where
// both quotients multiply by a constant reciprocal; each step has a register
// after it, and the result is on the ports after the last of these.
// Configuration: cfg_we with cfg_index 0..2 writes the 48-bit slot code words
// in the same cycle; index 3 is dropped. Write only while no item is in flight.
// Reset clears the code words (all slots off) and empties the pipeline;
// no done pulse appears until an item is taken after reset.
// The receiver cannot stall: every done beat is final.
module slot_schedule_burst_timer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sbt_pkg::EPOCH_W-1:0]   current_epoch,
    output logic                          done,
    output logic                          pump_on,
    output logic [sbt_pkg::EPOCH_W-1:0]   next_wake,
    input  logic                          cfg_we,
    input  logic [sbt_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [sbt_pkg::CFG_W-1:0]     cfg_data
);

    logic [sbt_pkg::CFG_W-1:0]    codes_first_reg;
    logic [sbt_pkg::CFG_W-1:0]    codes_middle_reg;
    logic [sbt_pkg::CFG_W-1:0]    codes_last_reg;

    sbt_pkg::split_t              split;

    logic [sbt_pkg::CFG_W-1:0]    code_word;
    logic [sbt_pkg::CODE_W-1:0]   code_next;
    logic [sbt_pkg::RECIP_W-1:0]  recip;
    logic [25:0]                  minq_prod;

    logic                         v3_reg;
    logic [sbt_pkg::EPOCH_W-1:0]  now3_reg;
    logic [sbt_pkg::REM_W-1:0]    rem3_reg;
    logic [sbt_pkg::CODE_W-1:0]   code3_reg;
    logic [sbt_pkg::MINQ_W-1:0]   minq3_reg;

    logic [sbt_pkg::DIV_W-1:0]    period;
    logic [sbt_pkg::ONLEN_W-1:0]  on_len;
    logic                         bursting;
    logic [sbt_pkg::REM_W-1:0]    period_base;
    logic [sbt_pkg::REM_W-1:0]    pos_raw;
    logic [sbt_pkg::REM_W-1:0]    pos;
    logic [sbt_pkg::EPOCH_W-1:0]  slot_end;
    logic [sbt_pkg::EPOCH_W-1:0]  edge_time;

    logic                         done_reg;
    logic                         pump_on_reg;
    logic                         pump_on_next;
    logic [sbt_pkg::EPOCH_W-1:0]  next_wake_reg;
    logic [sbt_pkg::EPOCH_W-1:0]  next_wake_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_first_reg  <= '0;
            codes_middle_reg <= '0;
            codes_last_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbt_pkg::REG_FIRST:  codes_first_reg  <= cfg_data;
                sbt_pkg::REG_MIDDLE: codes_middle_reg <= cfg_data;
                sbt_pkg::REG_LAST:   codes_last_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    sbt_slot_split u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_epoch (current_epoch),
        .split    (split)
    );

    always_comb
    begin
        unique case (split.slot[5:4])
            2'd0:    code_word = codes_first_reg;
            2'd1:    code_word = codes_middle_reg;
            2'd2:    code_word = codes_last_reg;
            default: code_word = '0;
        endcase
    end

    assign code_next = code_word[6'(split.slot[3:0]) * 6'd3 +: sbt_pkg::CODE_W];

    always_comb
    begin
        unique case (code_next)
            sbt_pkg::CODE_SHORT:  recip = sbt_pkg::RECIP_300;
            sbt_pkg::CODE_MEDIUM: recip = sbt_pkg::RECIP_120;
            default:              recip = sbt_pkg::RECIP_60;
        endcase
    end

    // quotient by the burst period, exact for any remainder below 1800
    assign minq_prod = 26'(split.rem) * 26'(recip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= split.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        now3_reg  <= split.now;
        rem3_reg  <= split.rem;
        code3_reg <= code_next;
        minq3_reg <= minq_prod[sbt_pkg::FRAC_W +: sbt_pkg::MINQ_W];
    end

    always_comb
    begin
        unique case (code3_reg)
            sbt_pkg::CODE_SHORT:
            begin
                period   = 9'd300;
                on_len   = 5'd5;
                bursting = 1'b1;
            end
            sbt_pkg::CODE_MEDIUM:
            begin
                period   = 9'd120;
                on_len   = 5'd10;
                bursting = 1'b1;
            end
            sbt_pkg::CODE_LONG:
            begin
                period   = 9'd60;
                on_len   = 5'd20;
                bursting = 1'b1;
            end
            default:
            begin
                period   = 9'd60;
                on_len   = 5'd0;
                bursting = 1'b0;
            end
        endcase
    end

    assign period_base = 11'(minq3_reg) * 11'(period);
    assign pos_raw     = rem3_reg - period_base;
    assign pos         = (pos_raw >= 11'(period)) ? pos_raw - 11'(period) : pos_raw;
    assign slot_end    = now3_reg + 32'(sbt_pkg::SLOT_SECONDS - rem3_reg);

    always_comb
    begin
        pump_on_next   = (code3_reg == sbt_pkg::CODE_ALWAYS);
        next_wake_next = slot_end;
        edge_time      = now3_reg + 32'(11'(period) - pos);
        if (bursting)
        begin
            if (pos < 11'(on_len))
            begin
                pump_on_next = 1'b1;
                edge_time    = now3_reg + 32'(11'(on_len) - pos);
            end
            if (edge_time < slot_end)
            begin
                next_wake_next = edge_time;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pump_on_reg   <= pump_on_next;
        next_wake_reg <= next_wake_next;
    end

    assign done      = done_reg;
    assign pump_on   = pump_on_reg;
    assign next_wake = next_wake_reg;

    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("result beat without a command five cycles earlier");

    a_cmd_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done)
        else $error("command beat lost in the pipeline");

    a_wake_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((next_wake - $past(current_epoch, 5)) != 32'd0 &&
                  (next_wake - $past(current_epoch, 5)) <= 32'd1800))
        else $error("next wake not within one slot after the command time");

endmodule
